[design/assert_macros.svh]
// Assertion macros used by the checker file.
// Include once; each macro expands to one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

[design/hrfc_pkg.sv]
// Package for the HTTP request framing checker: codes, phases and widths.
// No dependencies.
`default_nettype none
package hrfc_pkg;
	localparam int LINE_BYTES_DEF = 8192;
	localparam int LENGTH_DIGITS_DEF = 9;
	localparam int CHUNK_SIZE_DIGITS_DEF = 8;
	localparam logic [13:0] MIN_REQUEST_LINE = 14'd15;
	localparam logic [29:0] LENGTH_LIMIT = 30'h3FFF_FFFF;

	localparam logic [4:0] E_NONE = 5'd0;
	localparam logic [4:0] E_OVERFLOW = 5'd2;
	localparam logic [4:0] E_BAD_VERB = 5'd3;
	localparam logic [4:0] E_SYNTAX = 5'd4;
	localparam logic [4:0] E_BAD_VERSION = 5'd5;
	localparam logic [4:0] E_CR_NO_LF = 5'd6;
	localparam logic [4:0] E_HDR_CHAR = 5'd7;
	localparam logic [4:0] E_DOUBLE = 5'd8;
	localparam logic [4:0] E_CHUNK_HDR = 5'd9;
	localparam logic [4:0] E_CL_SYNTAX = 5'd10;
	localparam logic [4:0] E_CHUNK_CRLF = 5'd11;
	localparam logic [4:0] E_CHUNK_LONG = 5'd12;
	localparam logic [4:0] E_NON_HEX = 5'd14;
	localparam logic [4:0] E_BODY_NA = 5'd15;
	localparam logic [4:0] E_LF_NO_CR = 5'd16;

	localparam logic REG_BODY_MASK = 1'b0;
	localparam logic REG_MAX_LINE = 1'b1;

	typedef enum logic [5:0] {
		PH_REQUEST = 6'b000001,
		PH_HEADERS = 6'b000010,
		PH_BODY = 6'b000100,
		PH_CHUNK_LINE = 6'b001000,
		PH_CHUNK_DATA = 6'b010000,
		PH_DONE_WAIT = 6'b100000
	} phase_t;

	// Verb text, byte per position (0 past the end).
	function automatic logic [7:0] verb_char(input logic [2:0] v, input logic [4:0] i);
		logic [7:0] c;
		c = 8'h00;
		case (v)
			3'd0: case (i) 5'd0: c = "G"; 5'd1: c = "E"; 5'd2: c = "T"; default: c = 8'h00; endcase
			3'd1: case (i) 5'd0: c = "H"; 5'd1: c = "E"; 5'd2: c = "A"; 5'd3: c = "D";
				default: c = 8'h00; endcase
			3'd2: case (i) 5'd0: c = "P"; 5'd1: c = "O"; 5'd2: c = "S"; 5'd3: c = "T";
				default: c = 8'h00; endcase
			3'd3: case (i) 5'd0: c = "O"; 5'd1: c = "P"; 5'd2: c = "T"; 5'd3: c = "I";
				5'd4: c = "O"; 5'd5: c = "N"; 5'd6: c = "S"; default: c = 8'h00; endcase
			3'd4: case (i) 5'd0: c = "P"; 5'd1: c = "U"; 5'd2: c = "T"; default: c = 8'h00; endcase
			3'd5: case (i) 5'd0: c = "D"; 5'd1: c = "E"; 5'd2: c = "L"; 5'd3: c = "E";
				5'd4: c = "T"; 5'd5: c = "E"; default: c = 8'h00; endcase
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [4:0] verb_len(input logic [2:0] v);
		logic [4:0] n;
		case (v)
			3'd0: n = 5'd3;
			3'd1: n = 5'd4;
			3'd2: n = 5'd4;
			3'd3: n = 5'd7;
			3'd4: n = 5'd3;
			3'd5: n = 5'd6;
			default: n = 5'd31;
		endcase
		return n;
	endfunction

	localparam logic [14*8-1:0] CL_TEXT = "content-length";
	localparam logic [17*8-1:0] TE_TEXT = "transfer-encoding";
	localparam logic [7*8-1:0] CHUNKED_TEXT = "chunked";
	localparam logic [7*8-1:0] VERSION_TEXT = "HTTP/1.";

	function automatic logic [7:0] hdr_char(input logic h, input logic [4:0] i);
		logic [7:0] c;
		c = 8'h00;
		if (!h) begin
			if (i < 5'd14) c = CL_TEXT[8*(13 - i) +: 8];
		end else begin
			if (i < 5'd17) c = TE_TEXT[8*(16 - i) +: 8];
		end
		return c;
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] b);
		return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
	endfunction
endpackage
`default_nettype wire

[design/http_request_framing_checker_unit.sv]
// HTTP/1.x request framing checker: one stream byte in, one verdict out per word.
// A word is taken every clock while the output is not stalled; all checks for it run
// between the input register and the result register, so throughput is one byte per
// cycle. The first error latches and is reported on every later word until reset.
`default_nettype none
module http_request_framing_checker_unit
	import hrfc_pkg::*;
#(
	parameter int LINE_BYTES = LINE_BYTES_DEF,
	parameter int LENGTH_DIGITS = LENGTH_DIGITS_DEF,
	parameter int CHUNK_SIZE_DIGITS = CHUNK_SIZE_DIGITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [7:0] data_byte,
	output logic out_valid,
	input wire logic out_stall,
	output logic byte_ok,
	output logic [4:0] error_code,
	output logic is_body_byte,
	output logic request_done,
	input wire logic cfg_we,
	input wire logic cfg_index,
	input wire logic [13:0] cfg_data
);
	localparam logic [16:0] LINE_LIM = 17'(LINE_BYTES);

	logic [5:0] body_mask_q;
	logic [13:0] max_line_q;

	logic v_s1;
	logic [7:0] b_s1;

	phase_t phase_q, phase_d;
	logic [16:0] len_q, len_d;
	logic awaiting_q, awaiting_d;
	logic [1:0] part_q, part_d;
	logic [4:0] ti_q, ti_d;
	logic [11:0] mf_q, mf_d;
	logic seen_cl_q, seen_cl_d, seen_te_q, seen_te_d, vbody_q, vbody_d;
	logic [31:0] acc_q, acc_d;
	logic [29:0] decl_q, decl_d;
	logic [31:0] skip_q, skip_d;
	logic [1:0] cf_q, cf_d;
	logic [4:0] err_q, err_d;

	logic [4:0] code;
	logic body, done;
	logic adv_s1, take;
	logic [16:0] limit;
	logic [3:0] hexv;
	logic hex_ok;
	logic [35:0] mul10;

	// Stage 1 advances when stage 2 can take its word.
	assign adv_s1 = !out_valid || !out_stall;
	assign in_stall = !adv_s1;
	assign take = v_s1 && adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			body_mask_q <= 6'd20;
			max_line_q <= 14'd8192;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BODY_MASK: body_mask_q <= cfg_data[5:0];
				REG_MAX_LINE: max_line_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv_s1) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) b_s1 <= data_byte;
	end

	always_comb begin
		limit = (17'(max_line_q) > LINE_LIM) ? LINE_LIM : 17'(max_line_q);
		hex_ok = 1'b1;
		hexv = 4'd0;
		if (b_s1 >= "0" && b_s1 <= "9") hexv = 4'(b_s1 - "0");
		else if (b_s1 >= "a" && b_s1 <= "f") hexv = 4'(b_s1 - "a" + 8'd10);
		else if (b_s1 >= "A" && b_s1 <= "F") hexv = 4'(b_s1 - "A" + 8'd10);
		else hex_ok = 1'b0;
		mul10 = {4'd0, acc_q} * 36'd10 + 36'(b_s1 - "0");
	end

	always_comb begin
		phase_d = phase_q; len_d = len_q; awaiting_d = awaiting_q; part_d = part_q;
		ti_d = ti_q; mf_d = mf_q; seen_cl_d = seen_cl_q; seen_te_d = seen_te_q;
		vbody_d = vbody_q; acc_d = acc_q; decl_d = decl_q; skip_d = skip_q;
		cf_d = cf_q; err_d = err_q;
		code = E_NONE; body = 1'b0; done = 1'b0;
		if (err_q != E_NONE) begin
			code = err_q;
		end else if (awaiting_q) begin
			if (b_s1 == 8'h0A) begin
				awaiting_d = 1'b0;
				if (phase_q == PH_DONE_WAIT) begin
					phase_d = PH_REQUEST; done = 1'b1;
				end
			end else code = E_CR_NO_LF;
		end else if (phase_q == PH_BODY || phase_q == PH_CHUNK_DATA) begin
			body = 1'b1;
			skip_d = (skip_q != 32'd0) ? skip_q - 32'd1 : skip_q;
			if (skip_d == 32'd0) begin
				if (phase_q == PH_BODY) begin
					phase_d = PH_REQUEST; done = 1'b1;
				end else begin
					phase_d = PH_CHUNK_LINE; cf_d = 2'd1;
				end
			end
		end else if (b_s1 == 8'h0A) begin
			code = E_LF_NO_CR;
		end else if (len_q + 17'd1 > limit) begin
			code = E_OVERFLOW;
		end else begin
			len_d = len_q + 17'd1;
			if (b_s1 == 8'h0D) begin
				// Line end checks; len_d is the line length with its CR.
				if (phase_q == PH_HEADERS) begin
					if (len_d == 17'd1) begin
						if (seen_te_q) begin
							if (!vbody_q) code = E_BODY_NA;
							else begin phase_d = PH_CHUNK_LINE; cf_d = 2'd0; end
						end else if (seen_cl_q) begin
							if (!vbody_q && decl_q != 30'd0) code = E_BODY_NA;
							else begin
								skip_d = 32'(decl_q);
								phase_d = (decl_q != 30'd0) ? PH_BODY : PH_DONE_WAIT;
							end
						end else phase_d = PH_DONE_WAIT;
						if (code == E_NONE) begin
							seen_te_d = 1'b0; seen_cl_d = 1'b0; decl_d = 30'd0;
						end
					end else if (part_q != 2'd2 || mf_q[9]) code = E_SYNTAX;
					else if (mf_q[7]) code = E_HDR_CHAR;
					else if (mf_q[0]) begin
						if (seen_cl_q || seen_te_q) code = E_DOUBLE;
						else if (ti_q < 5'd1 || 32'(ti_q) > 32'(LENGTH_DIGITS) || mf_q[10]
							|| acc_q >= {2'b0, LENGTH_LIMIT} + 32'd1) code = E_CL_SYNTAX;
						else begin decl_d = acc_q[29:0]; seen_cl_d = 1'b1; end
					end else if (mf_q[1]) begin
						if (seen_cl_q || seen_te_q) code = E_DOUBLE;
						else if (!mf_q[8] || ti_q != 5'd7) code = E_CHUNK_HDR;
						else seen_te_d = 1'b1;
					end
				end else if (phase_q == PH_CHUNK_LINE) begin
					if (cf_q[1]) begin phase_d = PH_DONE_WAIT; cf_d = 2'd0; end
					else if (cf_q[0]) begin
						if (len_d != 17'd1) code = E_CHUNK_CRLF; else cf_d = 2'd0;
					end else if (len_d < 17'd2) code = E_CHUNK_HDR;
					else if (len_d - 17'd1 > 17'(CHUNK_SIZE_DIGITS)) code = E_CHUNK_LONG;
					else if (mf_q[7]) code = E_NON_HEX;
					else if (acc_q == 32'd0) cf_d = 2'd2;
					else begin skip_d = acc_q; phase_d = PH_CHUNK_DATA; end
				end else begin
					if (len_d < 17'(MIN_REQUEST_LINE) || part_q == 2'd0) code = E_SYNTAX;
					else if (!mf_q[6]) code = E_BAD_VERB;
					else if (part_q == 2'd1 || mf_q[7]) code = E_SYNTAX;
					else if (!mf_q[8] || ti_q != 5'd8) code = E_BAD_VERSION;
					else phase_d = PH_HEADERS;
				end
				if (code == E_NONE) begin
					awaiting_d = 1'b1; len_d = 17'd0; part_d = 2'd0; ti_d = 5'd0;
					mf_d = 12'h13F; acc_d = 32'd0;
				end
			end else if (phase_q == PH_HEADERS) begin
				if (part_q == 2'd0) begin
					if (b_s1 == ":") begin
						if (ti_q != 5'd14) mf_d[0] = 1'b0;
						if (ti_q != 5'd17) mf_d[1] = 1'b0;
						part_d = 2'd1;
					end else begin
						if (!((b_s1 >= "a" && b_s1 <= "z") || (b_s1 >= "A" && b_s1 <= "Z")
							|| (b_s1 >= "0" && b_s1 <= "9") || b_s1 == "-")) mf_d[7] = 1'b1;
						if (ti_q >= 5'd14 || hdr_char(1'b0, ti_q) != to_lower(b_s1))
							mf_d[0] = 1'b0;
						if (ti_q >= 5'd17 || hdr_char(1'b1, ti_q) != to_lower(b_s1))
							mf_d[1] = 1'b0;
						if (ti_q != 5'd31) ti_d = ti_q + 5'd1;
					end
				end else if (part_q == 2'd1) begin
					if (b_s1 != " ") mf_d[9] = 1'b1;
					part_d = 2'd2; ti_d = 5'd0;
				end else begin
					if (b_s1 >= "0" && b_s1 <= "9")
						acc_d = (mul10 > 36'h4000_0000) ? 32'h4000_0000 : mul10[31:0];
					else mf_d[10] = 1'b1;
					if (ti_q >= 5'd7 || CHUNKED_TEXT[8*(6 - 32'(ti_q)) +: 8] != b_s1)
						mf_d[8] = 1'b0;
					if (ti_q != 5'd31) ti_d = ti_q + 5'd1;
				end
			end else if (phase_q == PH_CHUNK_LINE) begin
				if (cf_q == 2'd0) begin
					if (!hex_ok) mf_d[7] = 1'b1;
					else if (32'(ti_q) < 32'(CHUNK_SIZE_DIGITS)) acc_d = {acc_q[27:0], hexv};
					if (ti_q != 5'd31) ti_d = ti_q + 5'd1;
				end
			end else begin
				if (part_q == 2'd0) begin
					if (b_s1 == " ") begin
						for (int i = 5; i >= 0; i--) begin
							if (mf_q[i] && verb_len(3'(i)) == ti_q) begin
								mf_d[6] = 1'b1; vbody_d = body_mask_q[i];
							end
						end
						part_d = 2'd1; ti_d = 5'd0;
					end else begin
						for (int i = 0; i < 6; i++) begin
							if (ti_q >= verb_len(3'(i)) || verb_char(3'(i), ti_q) != b_s1)
								mf_d[i] = 1'b0;
						end
						if (ti_q != 5'd31) ti_d = ti_q + 5'd1;
					end
				end else if (part_q == 2'd1) begin
					if (b_s1 == " ") begin part_d = 2'd2; ti_d = 5'd0; end
					else if (b_s1 == 8'h09 || b_s1 == 8'h00) mf_d[7] = 1'b1;
				end else begin
					if (ti_q < 5'd7) begin
						if (VERSION_TEXT[8*(6 - 32'(ti_q)) +: 8] != b_s1) mf_d[8] = 1'b0;
					end else if (ti_q == 5'd7) begin
						if (b_s1 != "0" && b_s1 != "1") mf_d[8] = 1'b0;
					end else mf_d[8] = 1'b0;
					if (ti_q != 5'd31) ti_d = ti_q + 5'd1;
				end
			end
		end
		if (code != E_NONE) begin
			err_d = code; body = 1'b0; done = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_REQUEST; len_q <= '0; awaiting_q <= 1'b0; part_q <= '0;
			ti_q <= '0; mf_q <= 12'h13F; seen_cl_q <= 1'b0; seen_te_q <= 1'b0;
			vbody_q <= 1'b0; acc_q <= '0; decl_q <= '0; skip_q <= '0; cf_q <= '0;
			err_q <= E_NONE;
		end else if (take) begin
			phase_q <= phase_d; len_q <= len_d; awaiting_q <= awaiting_d; part_q <= part_d;
			ti_q <= ti_d; mf_q <= mf_d; seen_cl_q <= seen_cl_d; seen_te_q <= seen_te_d;
			vbody_q <= vbody_d; acc_q <= acc_d; decl_q <= decl_d; skip_q <= skip_d;
			cf_q <= cf_d; err_q <= err_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv_s1) out_valid <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (take) begin
			byte_ok <= (code == E_NONE);
			error_code <= code;
			is_body_byte <= body;
			request_done <= done;
		end
	end
endmodule
`default_nettype wire

[design/hrfc_checker.sv]
// Port-level assertions for the framing checker, bound to the top level.
// Depends on assert_macros.svh and hrfc_pkg.
`default_nettype none
`include "assert_macros.svh"
module hrfc_checker
	import hrfc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic byte_ok,
	input wire logic [4:0] error_code,
	input wire logic is_body_byte,
	input wire logic request_done
);
	`ASSERT_IMPL(ok_no_code, clk, arst_n, out_valid && byte_ok, error_code == E_NONE)
	`ASSERT_IMPL(err_no_flags, clk, arst_n, out_valid && !byte_ok,
		error_code != E_NONE && !is_body_byte && !request_done)
	`ASSERT_NEXT(out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(error_code) && $stable(byte_ok))
	`ASSERT_NEXT(err_sticky, clk, arst_n, out_valid && !out_stall && !byte_ok,
		!out_valid || (!byte_ok && $past(error_code) == error_code) || $past(in_stall))
endmodule

bind http_request_framing_checker_unit hrfc_checker u_hrfc_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .byte_ok(byte_ok),
	.error_code(error_code), .is_body_byte(is_body_byte), .request_done(request_done)
);
`default_nettype wire
